// ----- rtl/core/cbf_pkg.sv -----
`timescale 1ns / 1ps

package cbf_pkg;

    // Field widths fixed by the interface
    localparam int unsigned MODE_W = 3;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 11;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Operation codes
    localparam mode_t MODE_PUSH     = 3'd0;
    localparam mode_t MODE_POP      = 3'd1;
    localparam mode_t MODE_PEEK     = 3'd2;
    localparam mode_t MODE_FLUSHN   = 3'd3;
    localparam mode_t MODE_FLUSHALL = 3'd4;
    localparam mode_t MODE_STATUS   = 3'd5;

    // Capacity after reset, before clamping to the storage depth
    localparam cnt_t CAP_RESET_VAL = 11'd1024;

endpackage

// ----- rtl/core/cbf_ifs.sv -----
`timescale 1ns / 1ps

// Operation request channel
interface cbf_req_if
    import cbf_pkg::*;
;
    logic  valid;
    logic  ready;
    mode_t mode;
    byte_t data_in;
    cnt_t  offset_or_count;

    modport source (output valid, output mode, output data_in, output offset_or_count,
                    input ready);
    modport sink   (input valid, input mode, input data_in, input offset_or_count,
                    output ready);
endinterface

// Result channel
interface cbf_rsp_if
    import cbf_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  ok;
    byte_t data_out;
    cnt_t  fill_level;
    cnt_t  peak_level;
    logic  is_empty;
    logic  is_full;

    modport source (output valid, output ok, output data_out, output fill_level,
                    output peak_level, output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input data_out, input fill_level,
                    input peak_level, input is_empty, input is_full, output ready);
endinterface

// Capacity register write channel
interface cbf_cfg_if
    import cbf_pkg::*;
;
    logic valid;
    logic ready;
    cnt_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/circular_byte_fifo_core.sv -----
`timescale 1ns / 1ps
// A word accepted on req shows up on rsp in the cycle after.
// Throughput: one word per cycle unless rsp stalls or a cfg write is pending;
//   results free as taken; the single-port RAM does one read or write per word.
// Reset: rst_n clears pointers, fill count, peak level and the result valid;
//   capacity returns to 1024 clamped to DEPTH. The byte RAM is not cleared.
module circular_byte_fifo_core
    import cbf_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
)(
    input  logic  clk,
    input  logic  rst_n,
    cbf_req_if.sink   req,
    cbf_rsp_if.source rsp,
    cbf_cfg_if.sink   cfg
);

    localparam int unsigned PTR_W     = $clog2(DEPTH);
    // Capacity can never exceed what the 11-bit field encodes
    localparam int unsigned CAP_LIMIT = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam cnt_t        CAP_MAX   = CNT_W'(CAP_LIMIT);
    localparam cnt_t        CAP_RST   = (CAP_MAX < CAP_RESET_VAL) ? CAP_MAX : CAP_RESET_VAL;

    typedef logic [PTR_W-1:0] ptr_t;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    ptr_t head_reg, head_next;
    ptr_t tail_reg, tail_next;
    cnt_t count_reg, count_next;
    cnt_t high_reg, high_next;
    cnt_t cap_reg;          // effective capacity, already clamped to 1..DEPTH
    logic rsp_valid_reg;

    // Result payload
    logic  ok_reg, ok_next;
    logic  dsel_reg, dsel_next;   // data_out comes from the RAM read
    cnt_t  fill_reg;
    cnt_t  peak_reg;
    logic  empty_reg;
    logic  full_reg;
    byte_t rd_data_reg;

    // Byte storage
    byte_t mem [DEPTH];

    logic  req_fire;
    logic  cfg_fire;
    logic  wr_en;
    ptr_t  rd_addr;
    cnt_t  cap_wr;

    // Shared tail adder: pop step, flush-n step and peek address
    cnt_t          tail_ext;
    cnt_t          step;
    logic [CNT_W:0] tail_sum;
    cnt_t          tail_wrap;
    cnt_t          head_inc;

    // The result register is refilled in the same cycle it is taken.
    // A pending capacity write holds off new words.
    assign req.ready = (!rsp_valid_reg || rsp.ready) && !cfg.valid;
    assign req_fire  = req.valid && req.ready;

    // Capacity is written only while no result word is waiting.
    assign cfg.ready = !rsp_valid_reg;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_comb
    begin
        if (cfg.data == '0)
            cap_wr = CNT_W'(1);
        else if (cfg.data > CAP_MAX)
            cap_wr = CAP_MAX;
        else
            cap_wr = cfg.data;
    end

    // Pointers stay below the capacity, so the 11-bit view is exact.
    assign tail_ext  = CNT_W'(tail_reg);
    assign step      = (req.mode == MODE_POP) ? CNT_W'(1) : req.offset_or_count;
    assign tail_sum  = {1'b0, tail_ext} + {1'b0, step};
    assign tail_wrap = (tail_sum >= {1'b0, cap_reg}) ? CNT_W'(tail_sum - {1'b0, cap_reg})
                                                     : CNT_W'(tail_sum);
    assign head_inc  = (CNT_W'(head_reg) + CNT_W'(1) == cap_reg) ? '0
                                                                 : CNT_W'(head_reg) + CNT_W'(1);

    // ------------------------------------------------------------------
    // Operation decode
    // ------------------------------------------------------------------
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        high_next  = high_reg;
        ok_next    = 1'b0;
        dsel_next  = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = tail_reg;

        unique case (req.mode)
            MODE_PUSH:
            begin
                if (count_reg < cap_reg)
                begin
                    ok_next    = 1'b1;
                    wr_en      = req_fire;
                    head_next  = PTR_W'(head_inc);
                    count_next = count_reg + CNT_W'(1);
                    if (count_next > high_reg)
                        high_next = count_next;
                end
            end
            MODE_POP:
            begin
                if (count_reg != '0)
                begin
                    ok_next    = 1'b1;
                    dsel_next  = 1'b1;
                    tail_next  = PTR_W'(tail_wrap);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_PEEK:
            begin
                rd_addr = PTR_W'(tail_wrap);
                if (req.offset_or_count < count_reg)
                begin
                    ok_next   = 1'b1;
                    dsel_next = 1'b1;
                end
            end
            MODE_FLUSHN:
            begin
                if (req.offset_or_count <= count_reg)
                begin
                    ok_next    = 1'b1;
                    tail_next  = PTR_W'(tail_wrap);
                    count_next = count_reg - req.offset_or_count;
                end
            end
            MODE_FLUSHALL:
            begin
                ok_next    = 1'b1;
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            MODE_STATUS:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            high_reg      <= '0;
            cap_reg       <= CAP_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                // New capacity empties the FIFO; the peak level is kept.
                cap_reg   <= cap_wr;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
            else if (req_fire)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                high_reg  <= high_next;
            end

            if (req_fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted word
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            ok_reg    <= ok_next;
            dsel_reg  <= dsel_next;
            fill_reg  <= count_next;
            peak_reg  <= high_next;
            empty_reg <= (count_next == '0);
            full_reg  <= (count_next == cap_reg);
        end
    end

    // Byte RAM: one write or one registered read per accepted word
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[head_reg] <= req.data_in;
        if (req_fire && !wr_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.data_out   = dsel_reg ? rd_data_reg : '0;
    assign rsp.fill_level = fill_reg;
    assign rsp.peak_level = peak_reg;
    assign rsp.is_empty   = empty_reg;
    assign rsp.is_full    = full_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("fill count above capacity");

    a_peak_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
        high_reg >= count_reg)
        else $error("peak level below fill count");

    a_head_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        {{CNT_W{1'b0}}, head_reg} < {{PTR_W{1'b0}}, cap_reg})
        else $error("head pointer outside capacity");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && !cfg_fire && wr_en) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not advance fill count");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (count_reg == '0 && head_reg == '0 && tail_reg == '0))
        else $error("capacity write did not empty the FIFO");

endmodule

// ----- tb/sv/circular_byte_fifo_core_tb.sv -----
`timescale 1ns / 1ps

module circular_byte_fifo_core_tb
    import cbf_pkg::*;
;
    localparam int unsigned DEPTH      = 1024;
    localparam int unsigned IDLE_LIMIT = 2000;  // cycles with no handshake anywhere
    localparam int unsigned PRINT_MAX  = 40;    // mismatch lines printed before going quiet

    // Codes the block must treat as no-ops
    localparam mode_t MODE_SPARE_6 = 3'd6;
    localparam mode_t MODE_SPARE_7 = 3'd7;

    // One request word and one result word
    typedef struct packed {
        mode_t mode;
        byte_t data;
        cnt_t  arg;
    } fifo_op_t;

    typedef struct packed {
        logic  ok;
        byte_t data;
        cnt_t  fill;
        cnt_t  peak;
        logic  is_empty;
        logic  is_full;
    } fifo_result_t;

    logic clk;
    logic rst_n = 1'b0;

    cbf_req_if req_if ();
    cbf_rsp_if rsp_if ();
    cbf_cfg_if cfg_if ();

    circular_byte_fifo_core #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Pending request words and the results predicted for accepted ones
    fifo_op_t     fifo_cmds[$];
    fifo_result_t rsp_due[$];

    // Shadow of the ring: storage, pointers, fill, peak and capacity register
    byte_t       ring_mem[DEPTH];
    int unsigned ring_wr   = 0;
    int unsigned ring_rd   = 0;
    int unsigned ring_fill = 0;
    int unsigned ring_peak = 0;
    cnt_t        cap_reg   = CAP_RESET_VAL;

    bit          stall_free = 1'b0;  // when set, neither side inserts gaps
    int unsigned req_gap    = 0;
    int unsigned rsp_hold   = 0;
    int unsigned idle_cycles = 0;
    int unsigned err_count  = 0;
    int unsigned rsp_count  = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Effective capacity: register value saturated to 1..DEPTH, so 0 acts as 1
    function automatic int unsigned cap_eff(cnt_t value);
        if (value == 0)
            return 1;
        if (value > DEPTH)
            return DEPTH;
        return value;
    endfunction

    // Applies one word to the shadow ring and returns the result it should produce.
    // Failing operations leave the ring untouched and report data 0.
    function automatic fifo_result_t apply_fifo_op(fifo_op_t op);
        fifo_result_t res;
        int unsigned  cap;
        int unsigned  arg;
        int unsigned  idx;
        res = '0;
        cap = cap_eff(cap_reg);
        arg = op.arg;
        case (op.mode)
            MODE_PUSH:
            begin
                if (ring_fill < cap)
                begin
                    ring_mem[ring_wr] = op.data;
                    ring_wr   = (ring_wr + 1 == cap) ? 0 : ring_wr + 1;
                    ring_fill = ring_fill + 1;
                    if (ring_fill > ring_peak)
                        ring_peak = ring_fill;
                    res.ok = 1'b1;
                end
            end
            MODE_POP:
            begin
                if (ring_fill > 0)
                begin
                    res.data  = ring_mem[ring_rd];
                    ring_rd   = (ring_rd + 1 == cap) ? 0 : ring_rd + 1;
                    ring_fill = ring_fill - 1;
                    res.ok    = 1'b1;
                end
            end
            MODE_PEEK:
            begin
                // offset counted from the tail, must land inside the held bytes
                if (arg < ring_fill)
                begin
                    idx = ring_rd + arg;
                    if (idx >= cap)
                        idx = idx - cap;
                    res.data = ring_mem[idx];
                    res.ok   = 1'b1;
                end
            end
            MODE_FLUSHN:
            begin
                // dropping zero bytes is a legal no-op
                if (arg <= ring_fill)
                begin
                    ring_rd = ring_rd + arg;
                    if (ring_rd >= cap)
                        ring_rd = ring_rd - cap;
                    ring_fill = ring_fill - arg;
                    res.ok    = 1'b1;
                end
            end
            MODE_FLUSHALL:
            begin
                // peak survives a flush-all
                ring_wr   = 0;
                ring_rd   = 0;
                ring_fill = 0;
                res.ok    = 1'b1;
            end
            MODE_STATUS:
            begin
                res.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.fill     = cnt_t'(ring_fill);
        res.peak     = cnt_t'(ring_peak);
        res.is_empty = (ring_fill == 0);
        res.is_full  = (ring_fill == cap);
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        err_count = err_count + 1;
        if (err_count <= PRINT_MAX)
            $display("[%0t] result word %0d: %s got %0d expected %0d",
                     $realtime, rsp_count, what, got, want);
    endtask

    // Request driver: holds a word until taken, then waits its drawn gap
    always @(posedge clk)
    begin : req_driver
        fifo_op_t op;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_gap      <= 0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (req_gap != 0)
            begin
                req_if.valid <= 1'b0;
                req_gap      <= req_gap - 1;
            end
            else if (fifo_cmds.size() != 0)
            begin
                op = fifo_cmds.pop_front();
                req_if.valid           <= 1'b1;
                req_if.mode            <= op.mode;
                req_if.data_in         <= op.data;
                req_if.offset_or_count <= op.arg;
                req_gap                <= stall_free ? 0 : $urandom_range(0, 5);
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result sink: after each word taken, drops ready for a drawn number of cycles
    always @(posedge clk)
    begin : rsp_sink
        int unsigned draw;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold     <= 0;
        end
        else if (rsp_if.valid && rsp_if.ready)
        begin
            draw = stall_free ? 0 : $urandom_range(0, 5);
            rsp_hold     <= draw;
            rsp_if.ready <= (draw == 0);
        end
        else if (rsp_hold != 0)
        begin
            rsp_hold     <= rsp_hold - 1;
            rsp_if.ready <= (rsp_hold == 1);
        end
        else
        begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor: checks results first, then folds in config and request words.
    // A result can never belong to a request taken at the same edge.
    always @(posedge clk)
    begin : monitor
        fifo_op_t     op;
        fifo_result_t got;
        fifo_result_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.ok       = rsp_if.ok;
                got.data     = rsp_if.data_out;
                got.fill     = rsp_if.fill_level;
                got.peak     = rsp_if.peak_level;
                got.is_empty = rsp_if.is_empty;
                got.is_full  = rsp_if.is_full;
                if (rsp_due.size() == 0)
                begin
                    report_mismatch("unexpected word, fill_level", got.fill, 0);
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (got.ok !== want.ok)
                        report_mismatch("ok", got.ok, want.ok);
                    if (got.data !== want.data)
                        report_mismatch("data_out", got.data, want.data);
                    if (got.fill !== want.fill)
                        report_mismatch("fill_level", got.fill, want.fill);
                    if (got.peak !== want.peak)
                        report_mismatch("peak_level", got.peak, want.peak);
                    if (got.is_empty !== want.is_empty)
                        report_mismatch("is_empty", got.is_empty, want.is_empty);
                    if (got.is_full !== want.is_full)
                        report_mismatch("is_full", got.is_full, want.is_full);
                end
                rsp_count = rsp_count + 1;
            end
            // capacity write empties the ring, peak is kept
            if (cfg_if.valid && cfg_if.ready)
            begin
                cap_reg   = cfg_if.data;
                ring_wr   = 0;
                ring_rd   = 0;
                ring_fill = 0;
            end
            if (req_if.valid && req_if.ready)
            begin
                op.mode = req_if.mode;
                op.data = req_if.data_in;
                op.arg  = req_if.offset_or_count;
                rsp_due.push_back(apply_fifo_op(op));
            end
        end
    end

    // Watchdog: a hung handshake ends the run
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic add_op(mode_t mode, byte_t data, cnt_t arg);
        fifo_op_t op;
        op.mode = mode;
        op.data = data;
        op.arg  = arg;
        fifo_cmds.push_back(op);
    endtask

    // Random mix biased toward push so small rings hit full and wrap often.
    // Offsets mostly sit near the live range; a few span the whole field.
    task automatic add_random_ops(int unsigned n, cnt_t cap_value);
        int unsigned span;
        int unsigned pick;
        int unsigned sel;
        cnt_t        arg;
        mode_t       mode;
        span = cap_eff(cap_value);
        if (span > 64)
            span = 64;
        for (int unsigned i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                mode = MODE_PUSH;
            else if (pick < 65)
                mode = MODE_POP;
            else if (pick < 80)
                mode = MODE_PEEK;
            else if (pick < 88)
                mode = MODE_FLUSHN;
            else if (pick < 91)
                mode = MODE_FLUSHALL;
            else if (pick < 97)
                mode = MODE_STATUS;
            else if (pick < 99)
                mode = MODE_SPARE_6;
            else
                mode = MODE_SPARE_7;
            sel = $urandom_range(0, 9);
            if (sel < 8)
                arg = cnt_t'($urandom_range(0, span + 1));
            else if (sel == 8)
                arg = cnt_t'($urandom_range(0, 2047));
            else
                arg = cnt_t'(span);
            add_op(mode, byte_t'($urandom_range(0, 255)), arg);
        end
    endtask

    // Waits until every word is sent and answered, then lets the pipe settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (fifo_cmds.size() != 0 || req_if.valid || rsp_due.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(cnt_t value);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Capacity settings for the random phases: zero and oversize saturate
    cnt_t cap_plan[10] = '{11'd1, 11'd0, 11'd2, 11'd3, 11'd7, 11'd16, 11'd2047,
                           11'd100, 11'd5, 11'd1};

    initial
    begin
        // known levels on every input before the first edge
        req_if.valid           = 1'b0;
        req_if.mode            = MODE_STATUS;
        req_if.data_in         = '0;
        req_if.offset_or_count = '0;
        rsp_if.ready           = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.data            = CAP_RESET_VAL;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity
        add_op(MODE_STATUS,   8'h00, 11'd0);
        add_op(MODE_POP,      8'h00, 11'd0);     // pop from empty
        add_op(MODE_PEEK,     8'h00, 11'd0);     // peek past fill
        add_op(MODE_FLUSHN,   8'h00, 11'd1);     // flush more than held
        add_op(MODE_FLUSHN,   8'h00, 11'd0);     // zero-byte flush succeeds
        add_op(MODE_PUSH,     8'h00, 11'd0);
        add_op(MODE_PUSH,     8'hFF, 11'd0);
        add_op(MODE_PUSH,     8'hA5, 11'd0);
        add_op(MODE_PEEK,     8'h00, 11'd0);
        add_op(MODE_PEEK,     8'h00, 11'd2);
        add_op(MODE_PEEK,     8'h00, 11'd3);
        add_op(MODE_PEEK,     8'h00, 11'd2047);
        add_op(MODE_SPARE_6,  8'h12, 11'd0);     // unused code
        add_op(MODE_SPARE_7,  8'hFF, 11'd2047);  // unused code
        add_op(MODE_POP,      8'h00, 11'd0);
        add_op(MODE_FLUSHN,   8'h00, 11'd5);
        add_op(MODE_FLUSHN,   8'h00, 11'd1);
        add_op(MODE_PUSH,     8'h5A, 11'd0);
        add_op(MODE_FLUSHALL, 8'h00, 11'd0);
        add_op(MODE_POP,      8'h00, 11'd0);
        add_op(MODE_PUSH,     8'h3C, 11'd1024);
        add_op(MODE_STATUS,   8'h00, 11'd0);

        // Random phases over a range of capacities, some without any gaps
        foreach (cap_plan[p])
        begin
            write_capacity(cap_plan[p]);
            stall_free <= ($urandom_range(0, 3) == 0);
            add_random_ops(40, cap_plan[p]);
        end

        // Full-depth capacity: offsets and counts at the edge of the capacity
        write_capacity(11'd1024);
        stall_free <= 1'b1;
        repeat (8)
            add_op(MODE_PUSH, byte_t'($urandom_range(0, 255)), 11'd0);
        add_op(MODE_PEEK,   8'h00, 11'd7);
        add_op(MODE_PEEK,   8'h00, 11'd1023);
        add_op(MODE_PEEK,   8'h00, 11'd1024);
        add_op(MODE_FLUSHN, 8'h00, 11'd1025);
        repeat (3)
            add_op(MODE_POP, 8'h00, 11'd0);
        add_op(MODE_FLUSHN, 8'h00, 11'd5);
        add_op(MODE_STATUS, 8'h00, 11'd0);
        wait_idle();
        stall_free <= 1'b0;
        add_random_ops(40, 11'd1024);

        // drain, then watch a little longer for stray result words
        wait_idle();
        repeat (8) @(posedge clk);
        if (rsp_due.size() != 0)
            report_mismatch("predictions left over", rsp_due.size(), 0);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
